/* src/tpcd_pkg.sv */
package tpcd_pkg;

    // Period table and search tree geometry
    localparam int TABLE_ENTRIES          = 60;
    localparam int PERIOD_TABLE_SIZE_DEF  = 60;
    localparam int GROUP_SIZE             = 8;
    localparam int LANES                  = GROUP_SIZE * GROUP_SIZE;
    localparam int IDX_W                  = 6;
    localparam int DIST_W                 = 12;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic
    {
        REG_SONG_LEN    = 1'b0,
        REG_SAMPLE_MASK = 1'b1
    } reg_sel_t;

    // Effect command nibbles that get sanitized
    localparam logic [3:0] CMD_PORTA_VOL = 4'h6;
    localparam logic [3:0] CMD_VOL_SLIDE = 4'hA;
    localparam logic [3:0] CMD_POS_JUMP  = 4'hB;
    localparam logic [3:0] CMD_SET_VOL   = 4'hC;
    localparam logic [3:0] CMD_BREAK     = 4'hD;
    localparam logic [3:0] CMD_EXT       = 4'hE;

    localparam logic [7:0]  VOL_MAX      = 8'h40;
    localparam logic [7:0]  BREAK_LIMIT  = 8'd64;
    localparam logic [11:0] EFF_VOL_MAX  = 12'hC40;
    localparam logic [11:0] EFF_BREAK_0  = 12'hD00;
    localparam logic [11:0] EFF_JUMP_0   = 12'hB00;

    typedef struct packed
    {
        logic [DIST_W-1:0] delta;
        logic [IDX_W-1:0]  idx;
    } cand_t;

    localparam cand_t CAND_PAD = '{delta: '1, idx: '0};

    // Later candidate wins only on a strictly smaller distance
    function automatic cand_t pick_cand(input cand_t a, input cand_t b);
        pick_cand = (b.delta < a.delta) ? b : a;
    endfunction

    function automatic logic [11:0] period_at(input logic [IDX_W-1:0] i);
        logic [11:0] p;
        case (i)
            6'd0:  p = 12'd1712;  6'd1:  p = 12'd1616;  6'd2:  p = 12'd1524;
            6'd3:  p = 12'd1440;  6'd4:  p = 12'd1356;  6'd5:  p = 12'd1280;
            6'd6:  p = 12'd1208;  6'd7:  p = 12'd1140;  6'd8:  p = 12'd1076;
            6'd9:  p = 12'd1016;  6'd10: p = 12'd960;   6'd11: p = 12'd906;
            6'd12: p = 12'd856;   6'd13: p = 12'd808;   6'd14: p = 12'd762;
            6'd15: p = 12'd720;   6'd16: p = 12'd678;   6'd17: p = 12'd640;
            6'd18: p = 12'd604;   6'd19: p = 12'd570;   6'd20: p = 12'd538;
            6'd21: p = 12'd508;   6'd22: p = 12'd480;   6'd23: p = 12'd453;
            6'd24: p = 12'd428;   6'd25: p = 12'd404;   6'd26: p = 12'd381;
            6'd27: p = 12'd360;   6'd28: p = 12'd339;   6'd29: p = 12'd320;
            6'd30: p = 12'd302;   6'd31: p = 12'd285;   6'd32: p = 12'd269;
            6'd33: p = 12'd254;   6'd34: p = 12'd240;   6'd35: p = 12'd226;
            6'd36: p = 12'd214;   6'd37: p = 12'd202;   6'd38: p = 12'd190;
            6'd39: p = 12'd180;   6'd40: p = 12'd170;   6'd41: p = 12'd160;
            6'd42: p = 12'd151;   6'd43: p = 12'd143;   6'd44: p = 12'd135;
            6'd45: p = 12'd127;   6'd46: p = 12'd120;   6'd47: p = 12'd113;
            6'd48: p = 12'd107;   6'd49: p = 12'd101;   6'd50: p = 12'd95;
            6'd51: p = 12'd90;    6'd52: p = 12'd85;    6'd53: p = 12'd80;
            6'd54: p = 12'd75;    6'd55: p = 12'd71;    6'd56: p = 12'd67;
            6'd57: p = 12'd63;    6'd58: p = 12'd60;    6'd59: p = 12'd56;
            default: p = 12'd0;
        endcase
        period_at = p;
    endfunction

endpackage

/* src/tracker_pattern_cell_decoder.sv */
// Tracker pattern cell decoder. Present one 4-byte cell on cell_word with start
// high; busy is never raised, so a new item may be started on every clock.
// Each item passes the three register stages of the nearest-period search and
// comes out as a one-cycle done strobe with sample_number, note_code and
// effect_word; the receiver cannot stall and must take the item in that cycle.
// The stages are: distances to every table entry, the minimum inside each
// group of eight, then the minimum across groups. Ties go to the earlier
// (lower-pitch) table entry, and a zero period gives note 0.
// song_length (offset 0x0) and sample_present_mask (offset 0x4) are written
// over APB and must only change while no item is in flight.
module tracker_pattern_cell_decoder #(
    parameter int PERIOD_TABLE_SIZE = tpcd_pkg::PERIOD_TABLE_SIZE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Item channel
    input  logic                            start,
    output logic                            busy,
    input  logic [31:0]                     cell_word,
    output logic                            done,
    output logic [4:0]                      sample_number,
    output logic [8:0]                      note_code,
    output logic [11:0]                     effect_word,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tpcd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tpcd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tpcd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import tpcd_pkg::*;

    // Entries actually searched: never more than the table holds
    localparam int SEARCH_N   = (PERIOD_TABLE_SIZE < TABLE_ENTRIES) ?
                                PERIOD_TABLE_SIZE : TABLE_ENTRIES;
    localparam int NUM_GROUPS = (SEARCH_N + GROUP_SIZE - 1) / GROUP_SIZE;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  song_length_reg;
    logic [30:0] sample_present_mask_reg;
    logic        cfg_write;
    reg_sel_t    cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_length_reg         <= 8'd1;
            sample_present_mask_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_SONG_LEN:    song_length_reg         <= pwdata[7:0];
                REG_SAMPLE_MASK: sample_present_mask_reg <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SONG_LEN:    prdata = {{(APB_DATA_W-8){1'b0}}, song_length_reg};
            REG_SAMPLE_MASK: prdata = {{(APB_DATA_W-31){1'b0}}, sample_present_mask_reg};
            default:         prdata = '0;
        endcase
    end

    // No backpressure anywhere: an item can enter on every clock
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: split the cell, sanitize effect, qualify sample, and take
    // the distance from the period to every table entry
    // ------------------------------------------------------------------
    logic                  accept;
    logic [31:0]           mask_ext;
    logic [4:0]            smp_low;
    logic                  smp_ok;
    logic [11:0]           period;
    logic [3:0]            cmd;
    logic [7:0]            par;

    logic                  s1_valid_reg;
    logic [4:0]            s1_sample_reg,  s1_sample_next;
    logic [11:0]           s1_effect_reg,  s1_effect_next;
    logic                  s1_pzero_reg,   s1_pzero_next;
    logic [DIST_W-1:0]     s1_dist_reg  [LANES];
    logic [DIST_W-1:0]     s1_dist_next [LANES];

    assign accept   = start && !busy;
    // Bit 0 stands for sample 0, which never counts as present
    assign mask_ext = {sample_present_mask_reg, 1'b0};
    assign smp_low  = {cell_word[28], cell_word[15:12]};
    // Sample number is byte0 high nibble * 16 + byte2 high nibble; above 31 drops
    assign smp_ok   = (cell_word[31:29] == 3'b000) && mask_ext[smp_low];
    assign period   = cell_word[27:16];
    assign cmd      = cell_word[11:8];
    assign par      = cell_word[7:0];

    always_comb
    begin
        s1_sample_next = smp_ok ? smp_low : 5'd0;
        s1_pzero_next  = (period == 12'd0);

        s1_effect_next = cell_word[11:0];
        case (cmd)
            CMD_PORTA_VOL, CMD_VOL_SLIDE:
            begin
                if ((par[7:4] != 4'd0) && (par[3:0] != 4'd0))
                    s1_effect_next = 12'd0;
            end
            CMD_POS_JUMP:
            begin
                if (song_length_reg == 8'd0)
                    s1_effect_next = EFF_JUMP_0;
                else if (par >= song_length_reg)
                    s1_effect_next = {CMD_POS_JUMP, song_length_reg - 8'd1};
            end
            CMD_SET_VOL:
            begin
                if (par > VOL_MAX)
                    s1_effect_next = EFF_VOL_MAX;
            end
            CMD_BREAK:
            begin
                if (par >= BREAK_LIMIT)
                    s1_effect_next = EFF_BREAK_0;
            end
            CMD_EXT:
            begin
                s1_effect_next = 12'd0;
            end
            default: ;
        endcase

        for (int i = 0; i < LANES; i++)
        begin
            if (i < SEARCH_N)
            begin
                if (period >= period_at(IDX_W'(i)))
                    s1_dist_next[i] = period - period_at(IDX_W'(i));
                else
                    s1_dist_next[i] = period_at(IDX_W'(i)) - period;
            end
            else
            begin
                s1_dist_next[i] = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_sample_reg <= s1_sample_next;
        s1_effect_reg <= s1_effect_next;
        s1_pzero_reg  <= s1_pzero_next;
        s1_dist_reg   <= s1_dist_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: nearest entry inside each group of eight
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    logic [4:0]  s2_sample_reg;
    logic [11:0] s2_effect_reg;
    logic        s2_pzero_reg;
    cand_t       s2_cand_reg  [GROUP_SIZE];
    cand_t       s2_cand_next [GROUP_SIZE];

    always_comb
    begin : grp_min
        cand_t l0 [8];
        cand_t l1 [4];
        cand_t l2 [2];
        for (int g = 0; g < GROUP_SIZE; g++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                l0[j].delta = s1_dist_reg[g*GROUP_SIZE + j];
                l0[j].idx   = IDX_W'(g*GROUP_SIZE + j);
            end
            for (int j = 0; j < 4; j++)
                l1[j] = pick_cand(l0[2*j], l0[2*j+1]);
            for (int j = 0; j < 2; j++)
                l2[j] = pick_cand(l1[2*j], l1[2*j+1]);
            if (g < NUM_GROUPS)
                s2_cand_next[g] = pick_cand(l2[0], l2[1]);
            else
                s2_cand_next[g] = CAND_PAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_sample_reg <= s1_sample_reg;
        s2_effect_reg <= s1_effect_reg;
        s2_pzero_reg  <= s1_pzero_reg;
        s2_cand_reg   <= s2_cand_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: nearest across groups, form note code, drive outputs
    // ------------------------------------------------------------------
    logic        done_reg;
    logic [4:0]  sample_reg;
    logic [8:0]  note_reg, note_next;
    logic [11:0] effect_reg;

    always_comb
    begin : fin_min
        cand_t f1 [4];
        cand_t f2 [2];
        cand_t best;
        for (int j = 0; j < 4; j++)
            f1[j] = pick_cand(s2_cand_reg[2*j], s2_cand_reg[2*j+1]);
        for (int j = 0; j < 2; j++)
            f2[j] = pick_cand(f1[2*j], f1[2*j+1]);
        best = pick_cand(f2[0], f2[1]);
        if (s2_pzero_reg)
            note_next = 9'd0;
        else
            note_next = {IDX_W'(best.idx + IDX_W'(1)), 3'b000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= s2_sample_reg;
        note_reg   <= note_next;
        effect_reg <= s2_effect_reg;
    end

    assign done          = done_reg;
    assign sample_number = sample_reg;
    assign note_code     = note_reg;
    assign effect_word   = effect_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("accepted item did not emerge after three cycles");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result strobe without a matching accepted item");

    a_sample_present: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (sample_number != 5'd0)) |-> mask_ext[sample_number])
        else $error("reported sample is not marked present");

    a_no_ext_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (effect_word[11:8] != CMD_EXT))
        else $error("extended command passed the sanitizer");

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((note_code[2:0] == 3'b000) && (note_code <= 9'(SEARCH_N * 8))))
        else $error("note code outside the searched table");

endmodule
